// ===== hw/rtl/rkpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary knob parameter editor package
// Shared widths, menu codes, transfer payload types and the sequencer states.
// ----------------------------------------------------------------------------
package rkpe_pkg;

  // Width of the quadrature counter that is compared between samples.
  localparam int CountBits = 16;

  localparam int FreqBits  = 24;
  localparam int ScaleBits = 20;
  localparam int DutyBits  = 7;
  localparam int StepBits  = $clog2(FreqBits);

  // The step scale is always a power of ten, kept as its exponent.
  localparam int          ScaleExpMax  = 6;
  localparam int          ScaleExpBits = 3;

  localparam logic [1:0] MenuFreq  = 2'd0;
  localparam logic [1:0] MenuScale = 2'd1;
  localparam logic [1:0] MenuDuty  = 2'd2;
  localparam logic [1:0] MenuSave  = 2'd3;

  localparam logic KindKnob   = 1'b0;
  localparam logic KindButton = 1'b1;

  localparam logic [CountBits-1:0] LastCountReset = CountBits'(32'h7FFF);
  localparam logic [FreqBits-1:0]  MaxFreqReset   = FreqBits'(8000000);
  localparam logic [DutyBits-1:0]  MaxDutyReset   = DutyBits'(100);
  localparam logic [DutyBits-1:0]  DutyReset      = DutyBits'(50);

  typedef struct packed {
    logic        kind;
    logic [15:0] knob_count;
  } rkpe_in_t;

  typedef struct packed {
    logic [1:0]  menu_item;
    logic        editing;
    logic [23:0] frequency_value;
    logic [19:0] step_scale;
    logic [6:0]  duty_value;
    logic        save_choice;
  } rkpe_out_t;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StApply,
    StEmit
  } rkpe_state_e;

  // Power of ten for a scale exponent.
  function automatic logic [ScaleBits-1:0] pow10(input logic [ScaleExpBits-1:0] e);
    logic [ScaleBits-1:0] v;
    unique case (e)
      3'd0:    v = ScaleBits'(1);
      3'd1:    v = ScaleBits'(10);
      3'd2:    v = ScaleBits'(100);
      3'd3:    v = ScaleBits'(1000);
      3'd4:    v = ScaleBits'(10000);
      3'd5:    v = ScaleBits'(100000);
      3'd6:    v = ScaleBits'(1000000);
      default: v = ScaleBits'(1);
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/rotary_knob_parameter_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary knob parameter editor
// Front-panel editor for a PWM generator: knob samples and button presses
// move through a four-item menu and edit frequency, scale, duty and save.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  -------------------------
//  in       sink       in_valid_i / in_stall_o   rkpe_in_t  (kind, count)
//  out      source     out_valid_o / out_stall_i rkpe_out_t (menu state)
//  cfg      APB slave  psel/penable/pwrite       max_frequency, max_duty
//
// A button press, a zero turn or any turn other than a frequency edit
// goes from idle to the emit state. A frequency edit first passes the
// divide and apply states: one shared 21-bit subtractor runs a 24-step
// restoring division of frequency by scale for the scale's decimal digit.
// All control state clears on the asynchronous reset. A stalled result is
// held in the output register; the block takes the next item meanwhile and
// only waits if it finishes before the held result has been taken.
module rotary_knob_parameter_editor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rkpe_pkg::rkpe_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rkpe_pkg::rkpe_out_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rkpe_pkg::*;

  // Sequencer and editor state.
  rkpe_state_e             state_q, state_d;
  logic [1:0]              menu_q, menu_d;
  logic                    edit_q, edit_d;
  logic [FreqBits-1:0]     freq_q, freq_d;
  logic [ScaleExpBits-1:0] scale_exp_q, scale_exp_d;
  logic [DutyBits-1:0]     duty_q, duty_d;
  logic                    save_q, save_d;
  logic [CountBits-1:0]    last_q, last_d;

  // Divider working registers.
  logic                    dir_up_q, dir_up_d;
  logic [ScaleBits-1:0]    rem_q, rem_d;
  logic [3:0]              digit_q, digit_d;
  logic [StepBits-1:0]     step_q, step_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  rkpe_out_t               out_q, out_d;

  // Configuration registers.
  logic [FreqBits-1:0]     max_freq_q;
  logic [DutyBits-1:0]     max_duty_q;

  logic                    in_fire;
  logic                    cfg_write;
  logic [CountBits-1:0]    cur_count;
  logic [CountBits-1:0]    diff;
  logic                    turn_up;
  logic [ScaleBits-1:0]    scale;
  logic [ScaleBits:0]      trial;
  logic                    trial_ge;
  logic [4:0]              digit_dbl;
  logic [FreqBits:0]       freq_sum;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // The address decodes on bit 2 alone: byte address 0 is the frequency
  // limit and byte address 4 the duty limit.
  assign prdata = paddr[2] ? 32'(max_duty_q) : 32'(max_freq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_freq_q <= MaxFreqReset;
      max_duty_q <= MaxDutyReset;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        max_duty_q <= pwdata[DutyBits-1:0];
      end else begin
        max_freq_q <= pwdata[FreqBits-1:0];
      end
    end
  end

  // Items are taken only while the sequencer is idle.
  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;

  // The turn direction is the sign of the wrapped counter difference.
  assign cur_count = in_item_i.knob_count[CountBits-1:0];
  assign diff      = cur_count - last_q;
  assign turn_up   = !diff[CountBits-1];

  assign scale = pow10(scale_exp_q);

  // One restoring division step, most significant frequency bit first. The
  // quotient is only needed modulo ten, so it is folded as it is built.
  assign trial     = {rem_q, freq_q[step_q]};
  assign trial_ge  = (trial >= {1'b0, scale});
  assign digit_dbl = {digit_q, trial_ge};

  assign freq_sum = {1'b0, freq_q} + {{(FreqBits + 1 - ScaleBits){1'b0}}, scale};

  always_comb begin
    state_d     = state_q;
    menu_d      = menu_q;
    edit_d      = edit_q;
    freq_d      = freq_q;
    scale_exp_d = scale_exp_q;
    duty_d      = duty_q;
    save_d      = save_q;
    last_d      = last_q;
    dir_up_d    = dir_up_q;
    rem_d       = rem_q;
    digit_d     = digit_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // The held result leaves once the receiver takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StEmit;
          if (in_item_i.kind == KindButton) begin
            edit_d = !edit_q;
          end else begin
            last_d = cur_count;
            if (diff != '0) begin
              if (!edit_q) begin
                if (turn_up && menu_q != MenuSave) begin
                  menu_d = menu_q + 2'd1;
                end else if (!turn_up && menu_q != MenuFreq) begin
                  menu_d = menu_q - 2'd1;
                end
              end else begin
                unique case (menu_q)
                  MenuFreq: begin
                    // The digit test needs the divider first.
                    state_d  = StDiv;
                    dir_up_d = turn_up;
                    rem_d    = '0;
                    digit_d  = '0;
                    step_d   = StepBits'(FreqBits - 1);
                  end
                  MenuScale: begin
                    if (turn_up && scale_exp_q < ScaleExpBits'(ScaleExpMax)) begin
                      scale_exp_d = scale_exp_q + 1'b1;
                    end else if (!turn_up && scale_exp_q != '0) begin
                      scale_exp_d = scale_exp_q - 1'b1;
                    end
                  end
                  MenuDuty: begin
                    if (turn_up && duty_q < max_duty_q) begin
                      duty_d = duty_q + 1'b1;
                    end else if (!turn_up && duty_q != '0) begin
                      duty_d = duty_q - 1'b1;
                    end
                  end
                  MenuSave: begin
                    save_d = !save_q;
                  end
                  default: begin
                    save_d = save_q;
                  end
                endcase
              end
            end
          end
        end
      end

      StDiv: begin
        rem_d   = trial_ge ? ScaleBits'(trial - {1'b0, scale}) : trial[ScaleBits-1:0];
        digit_d = (digit_dbl >= 5'd10) ? 4'(digit_dbl - 5'd10) : digit_dbl[3:0];
        step_d  = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = StApply;
        end
      end

      StApply: begin
        // No carry or borrow: the digit at the scale must stay within 0..9.
        if (dir_up_q && digit_q < 4'd9 && freq_sum <= {1'b0, max_freq_q}) begin
          freq_d = freq_sum[FreqBits-1:0];
        end else if (!dir_up_q && digit_q != '0 &&
                     freq_q >= {{(FreqBits - ScaleBits){1'b0}}, scale}) begin
          freq_d = freq_q - {{(FreqBits - ScaleBits){1'b0}}, scale};
        end
        state_d = StEmit;
      end

      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d               = 1'b1;
          out_d.menu_item           = menu_q;
          out_d.editing             = edit_q;
          out_d.frequency_value     = freq_q;
          out_d.step_scale          = scale;
          out_d.duty_value          = duty_q;
          out_d.save_choice         = save_q;
          state_d                   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      menu_q      <= MenuSave;
      edit_q      <= 1'b0;
      freq_q      <= '0;
      scale_exp_q <= '0;
      duty_q      <= DutyReset;
      save_q      <= 1'b0;
      last_q      <= LastCountReset;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      menu_q      <= menu_d;
      edit_q      <= edit_d;
      freq_q      <= freq_d;
      scale_exp_q <= scale_exp_d;
      duty_q      <= duty_d;
      save_q      <= save_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  // Divider data and the result payload need no reset.
  always_ff @(posedge clk_i) begin
    dir_up_q <= dir_up_d;
    rem_q    <= rem_d;
    digit_q  <= digit_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // The scale exponent never passes six, so the scale never passes one million.
  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_exp_q <= ScaleExpBits'(ScaleExpMax))
    else $error("scale exponent out of range");

  // Every transfer in leaves the sequencer busy with that item.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != StIdle))
    else $error("accepted item did not start work");

  // The folded quotient digit stays a decimal digit during division.
  a_digit_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv || state_q == StApply) |-> (digit_q < 4'd10))
    else $error("divider digit not decimal");

  // A finished division always goes straight to the update step.
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && step_q == '0) |=> (state_q == StApply))
    else $error("division did not finish in order");
`endif

endmodule
